// ===== sv/bebs_pkg.sv =====
// Shared types and codes of the beat event block scheduler.
package bebs_pkg;

  localparam logic [1:0] FUNC_SCHED = 2'd0;
  localparam logic [1:0] FUNC_RETR  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [1:0] KIND_ACCEPT = 2'd0;
  localparam logic [1:0] KIND_REFUSE = 2'd1;
  localparam logic [1:0] KIND_MATCH  = 2'd2;
  localparam logic [1:0] KIND_EMPTY  = 2'd3;

  localparam logic [2:0] REG_SPB        = 3'd0;
  localparam logic [2:0] REG_LOOP_START = 3'd1;
  localparam logic [2:0] REG_LOOP_END   = 3'd2;
  localparam logic [2:0] REG_BLOCK      = 3'd3;
  localparam logic [2:0] REG_EXPIRY     = 3'd4;
  localparam logic [2:0] REG_LATE       = 3'd5;

  localparam logic [13:0] BLOCK_MAX = 14'd8192;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] beat_time;
    logic [15:0]        target_node;
    logic [3:0]         event_type;
    logic [3:0]         channel;
    logic [7:0]         data_one;
    logic [7:0]         data_two;
    logic [31:0]        value_bits;
    logic [30:0]        block_start;
    logic [30:0]        block_end;
    logic               looped;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [12:0] sample_offset;
    logic [15:0] out_node;
    logic [3:0]  out_type;
    logic [3:0]  out_channel;
    logic [7:0]  out_data_one;
    logic [7:0]  out_data_two;
    logic [31:0] out_value_bits;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [31:0] samples_per_beat;
    logic [30:0] loop_start;
    logic [30:0] loop_end;
    logic [13:0] block_samples;
    logic [30:0] expiry_beats;
    logic [30:0] late_tolerance;
  } cfg_t;

  typedef struct packed {
    logic [15:0] node;
    logic [3:0]  etype;
    logic [3:0]  chan;
    logic [7:0]  data_one;
    logic [7:0]  data_two;
    logic [31:0] value_bits;
  } payload_t;

  typedef struct packed {
    logic [30:0] beat;
    payload_t    pl;
  } entry_t;

  typedef struct packed {
    logic [12:0] offset;
    payload_t    pl;
  } match_t;

endpackage

// ===== sv/beat_event_block_scheduler_core.sv =====
// Top level of the beat event block scheduler: sequencer around staging and match RAMs.
// Schedule, clear and unused function items are answered from the idle state. A retrieve
// item runs prepare, multiply and round setup states, then per staged entry the read,
// evaluate, multiply and offset states (and a move state if a removed entry is refilled
// from the end of the table), sharing the staging RAM's single read port and the 32 by 32 multiplier;
// each match is found by a pass over the match RAM. The block takes one item at a time.
module beat_event_block_scheduler_core import bebs_pkg::*; #(
  parameter int STAGING_DEPTH = 256,
  parameter int MAX_OUT       = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW  = $clog2(STAGING_DEPTH);
  localparam int CW  = $clog2(STAGING_DEPTH + 1);
  localparam int MIW = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
  localparam int MW  = $clog2(MAX_OUT + 1);

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_PREP = 12'b000000000010,
    S_WMUL = 12'b000000000100,
    S_WRND = 12'b000000001000,
    S_RD   = 12'b000000010000,
    S_EV   = 12'b000000100000,
    S_MUL  = 12'b000001000000,
    S_OFS  = 12'b000010000000,
    S_MV   = 12'b000100000000,
    S_FSET = 12'b001000000000,
    S_FIND = 12'b010000000000,
    S_OUT  = 12'b100000000000
  } state_t;

  cfg_t   cfg;
  state_t state;

  logic [CW-1:0]      count;
  logic [IW-1:0]      idx;
  logic [30:0]        bs;
  logic [30:0]        be;
  logic               looped;
  logic               wrapped;
  logic signed [33:0] loop_len;
  logic signed [33:0] tol;
  logic [13:0]        limit;
  logic signed [33:0] wrap;
  logic               wneg;
  logic [31:0]        mul_a;
  logic [63:0]        prod;
  payload_t           ent;
  logic               expire;
  logic               cand;
  logic               use_wrap;
  logic               late_ok;
  logic [MW-1:0]      mcount;
  logic [MW-1:0]      iss;
  logic               rv;
  logic [MIW-1:0]     rk;
  logic               have;
  match_t             best;
  logic [MIW-1:0]     best_k;
  logic [MW-1:0]      emitted;
  logic [MAX_OUT-1:0] done;

  logic               s_we;
  logic [IW-1:0]      s_waddr;
  entry_t             s_wdata;
  logic               s_re;
  logic [IW-1:0]      s_raddr;
  entry_t             s_rdata;
  logic               m_we;
  logic               m_re;
  match_t             m_wdata;
  match_t             m_rdata;

  logic               accept;
  logic               slot_free;
  logic               sched_ok;
  logic               rsp_load;
  logic [1:0]         idle_kind;
  logic [CW-1:0]      last_pos;
  logic               at_last;
  logic [63:0]        psum;
  logic [31:0]        rnd;
  logic signed [33:0] beat34;
  logic signed [33:0] bs34;
  logic signed [33:0] be34;
  logic signed [33:0] ls34;
  logic signed [33:0] le34;
  logic signed [33:0] ahead;
  logic signed [33:0] back;
  logic signed [33:0] dw;
  logic signed [33:0] dw_abs;
  logic signed [33:0] duration;
  logic               expire_c;
  logic               cand_c;
  logic               uw_c;
  logic [30:0]        diff_c;
  logic               late_c;
  logic signed [33:0] offs_raw;
  logic signed [33:0] offs_pos;
  logic [12:0]        offs_q;
  logic               match_c;
  logic               remove_c;
  logic               buf_room;
  logic               out_last;

  bebs_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  bebs_ram #(.DEPTH(STAGING_DEPTH), .WIDTH($bits(entry_t)), .ADDR_W(IW)) u_stage (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .re(s_re), .raddr(s_raddr), .rdata(s_rdata)
  );

  bebs_ram #(.DEPTH(MAX_OUT), .WIDTH($bits(match_t)), .ADDR_W(MIW)) u_match (
    .clk, .we(m_we), .waddr(mcount[MIW-1:0]), .wdata(m_wdata),
    .re(m_re), .raddr(iss[MIW-1:0]), .rdata(m_rdata)
  );

  assign slot_free = !rsp_valid || !rsp_stall;
  assign req_stall = rst || (state != S_IDLE) || !slot_free;
  assign accept    = req_valid && !req_stall;
  assign sched_ok  = !req.beat_time[31] && (count != CW'(STAGING_DEPTH));
  assign rsp_load  = ((state == S_IDLE) && accept) || ((state == S_OUT) && slot_free);
  assign last_pos  = count - CW'(1);
  assign at_last   = (CW'(idx) == last_pos);
  assign buf_room  = (mcount < MW'(MAX_OUT));
  assign out_last  = ((emitted + MW'(1)) == mcount);

  always_comb begin
    case (req.func)
      FUNC_SCHED: idle_kind = sched_ok ? KIND_ACCEPT : KIND_REFUSE;
      FUNC_CLEAR: idle_kind = KIND_EMPTY;
      default:    idle_kind = KIND_REFUSE;
    endcase
  end

  always_comb begin
    psum   = prod + 64'h0000_0000_8000_0000;
    rnd    = psum[63:32];
    beat34 = $signed({3'b000, s_rdata.beat});
    bs34   = $signed({3'b000, bs});
    be34   = $signed({3'b000, be});
    ls34   = $signed({3'b000, cfg.loop_start});
    le34   = $signed({3'b000, cfg.loop_end});
    dw     = le34 - bs34;
    dw_abs = (dw < 0) ? -dw : dw;
    duration = wrapped ? (le34 - bs34) + (be34 - ls34) : (be34 - bs34);

    if (!looped || (s_rdata.beat >= bs)) begin
      ahead = beat34 - bs34;
    end else begin
      ahead = (le34 - bs34) + (beat34 - ls34);
    end
    if (!looped) begin
      expire_c = (ahead < -$signed({3'b000, cfg.expiry_beats}));
    end else begin
      expire_c = (ahead > loop_len);
    end

    cand_c = 1'b0;
    uw_c   = 1'b0;
    diff_c = s_rdata.beat - bs;
    if (!wrapped) begin
      cand_c = (s_rdata.beat >= bs) && (s_rdata.beat < be);
    end else if ((s_rdata.beat >= bs) && (s_rdata.beat < cfg.loop_end)) begin
      cand_c = 1'b1;
    end else if ((s_rdata.beat >= cfg.loop_start) && (s_rdata.beat < be)) begin
      cand_c = 1'b1;
      uw_c   = 1'b1;
      diff_c = s_rdata.beat - cfg.loop_start;
    end
    back   = bs34 - beat34;
    late_c = (back > 0) && (back <= tol);

    offs_raw = cand ? ((use_wrap ? wrap : 34'sd0) + $signed({2'b00, rnd})) : -34'sd1;
    offs_pos = (offs_raw < 0) ? 34'sd0 : offs_raw;
    if (offs_pos >= $signed({20'd0, limit})) begin
      offs_q = 13'(limit - 14'd1);
    end else begin
      offs_q = offs_pos[12:0];
    end
    match_c  = !expire && ((offs_raw >= 0) || late_ok);
    remove_c = expire || match_c;
  end

  always_comb begin
    s_we    = 1'b0;
    s_waddr = idx;
    s_wdata = s_rdata;
    s_re    = 1'b0;
    s_raddr = idx;
    if (state == S_IDLE) begin
      s_we    = accept && (req.func == FUNC_SCHED) && sched_ok;
      s_waddr = count[IW-1:0];
      s_wdata.beat          = req.beat_time[30:0];
      s_wdata.pl.node       = req.target_node;
      s_wdata.pl.etype      = req.event_type;
      s_wdata.pl.chan       = req.channel;
      s_wdata.pl.data_one   = req.data_one;
      s_wdata.pl.data_two   = req.data_two;
      s_wdata.pl.value_bits = req.value_bits;
    end
    if (state == S_MV) begin
      s_we = 1'b1;
    end
    if (state == S_RD) begin
      s_re = 1'b1;
    end
    if ((state == S_OFS) && remove_c && !at_last) begin
      s_re    = 1'b1;
      s_raddr = last_pos[IW-1:0];
    end
    m_we           = (state == S_OFS) && match_c && buf_room;
    m_wdata.offset = offs_q;
    m_wdata.pl     = ent;
    m_re           = (state == S_FIND) && (iss < mcount);
  end

  always_ff @(posedge clk) begin
    if (state == S_WMUL || state == S_MUL) begin
      prod <= mul_a * cfg.samples_per_beat;
    end
    if (state == S_PREP) begin
      mul_a    <= dw_abs[31:0];
      wneg     <= (dw < 0);
      loop_len <= le34 - ls34;
      tol      <= looped ? duration : $signed({3'b000, cfg.late_tolerance});
      if (cfg.block_samples == 14'd0) begin
        limit <= 14'd1;
      end else if (cfg.block_samples > BLOCK_MAX) begin
        limit <= BLOCK_MAX;
      end else begin
        limit <= cfg.block_samples;
      end
    end
    if (state == S_WRND) begin
      wrap <= wneg ? -$signed({2'b00, rnd}) : $signed({2'b00, rnd});
    end
    if (state == S_EV) begin
      ent      <= s_rdata.pl;
      expire   <= expire_c;
      cand     <= cand_c;
      use_wrap <= uw_c;
      late_ok  <= late_c;
      mul_a    <= {1'b0, diff_c};
    end
    if (accept && (req.func == FUNC_RETR)) begin
      bs      <= req.block_start;
      be      <= req.block_end;
      looped  <= req.looped;
      wrapped <= req.looped && (req.block_end < req.block_start);
    end
    if ((state == S_FIND) && rv && !done[rk] && (!have || (m_rdata.offset < best.offset))) begin
      best   <= m_rdata;
      best_k <= rk;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
      rsp       <= '0;
      idx       <= '0;
      mcount    <= '0;
      iss       <= '0;
      rv        <= 1'b0;
      rk        <= '0;
      have      <= 1'b0;
      emitted   <= '0;
      done      <= '0;
    end else begin
      if (rsp_valid && !rsp_stall && !rsp_load) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            rsp       <= '{kind: idle_kind, last: 1'b1, default: '0};
            rsp_valid <= (req.func != FUNC_RETR);
            case (req.func)
              FUNC_SCHED: begin
                if (sched_ok) begin
                  count <= count + CW'(1);
                end
              end
              FUNC_RETR: begin
                mcount  <= '0;
                emitted <= '0;
                done    <= '0;
                state   <= S_PREP;
              end
              FUNC_CLEAR: begin
                count <= '0;
              end
              default: ;
            endcase
          end
        end
        S_PREP: state <= S_WMUL;
        S_WMUL: state <= S_WRND;
        S_WRND: begin
          idx   <= last_pos[IW-1:0];
          state <= (count == '0) ? S_FSET : S_RD;
        end
        S_RD:  state <= S_EV;
        S_EV:  state <= S_MUL;
        S_MUL: state <= S_OFS;
        S_OFS: begin
          if (m_we) begin
            mcount <= mcount + MW'(1);
          end
          if (remove_c) begin
            count <= last_pos;
          end
          if (remove_c && !at_last) begin
            state <= S_MV;
          end else if (idx == '0) begin
            state <= S_FSET;
          end else begin
            idx   <= idx - IW'(1);
            state <= S_RD;
          end
        end
        S_MV: begin
          if (idx == '0) begin
            state <= S_FSET;
          end else begin
            idx   <= idx - IW'(1);
            state <= S_RD;
          end
        end
        S_FSET: begin
          iss   <= '0;
          rv    <= 1'b0;
          have  <= 1'b0;
          state <= (mcount == '0) ? S_OUT : S_FIND;
        end
        S_FIND: begin
          rv <= m_re;
          rk <= iss[MIW-1:0];
          if (m_re) begin
            iss <= iss + MW'(1);
          end
          if (rv && !done[rk]) begin
            have <= 1'b1;
          end
          if (!m_re && !rv) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (slot_free) begin
            rsp_valid <= 1'b1;
            if (mcount == '0) begin
              rsp   <= '{kind: KIND_EMPTY, last: 1'b1, default: '0};
              state <= S_IDLE;
            end else begin
              rsp <= '{kind: KIND_MATCH,
                       sample_offset: best.offset,
                       out_node: best.pl.node,
                       out_type: best.pl.etype,
                       out_channel: best.pl.chan,
                       out_data_one: best.pl.data_one,
                       out_data_two: best.pl.data_two,
                       out_value_bits: best.pl.value_bits,
                       last: out_last};
              done[best_k] <= 1'b1;
              emitted      <= emitted + MW'(1);
              state        <= out_last ? S_IDLE : S_FSET;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/bebs_ram.sv =====
// Simple dual-port synchronous RAM with a registered read.
module bebs_ram #(
  parameter int DEPTH  = 256,
  parameter int WIDTH  = 8,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/bebs_cfg.sv =====
// Configuration register file behind the APB-style port.
module bebs_cfg import bebs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic [2:0] index;

  assign index  = paddr[4:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.samples_per_beat <= 32'd1572864000;
      cfg.loop_start       <= 31'd0;
      cfg.loop_end         <= 31'd262144;
      cfg.block_samples    <= 14'd512;
      cfg.expiry_beats     <= 31'd65536;
      cfg.late_tolerance   <= 31'd32768;
    end else if (psel && penable && pwrite) begin
      case (index)
        REG_SPB:        cfg.samples_per_beat <= pwdata;
        REG_LOOP_START: cfg.loop_start       <= pwdata[30:0];
        REG_LOOP_END:   cfg.loop_end         <= pwdata[30:0];
        REG_BLOCK:      cfg.block_samples    <= pwdata[13:0];
        REG_EXPIRY:     cfg.expiry_beats     <= pwdata[30:0];
        REG_LATE:       cfg.late_tolerance   <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_SPB:        prdata = cfg.samples_per_beat;
      REG_LOOP_START: prdata = {1'b0, cfg.loop_start};
      REG_LOOP_END:   prdata = {1'b0, cfg.loop_end};
      REG_BLOCK:      prdata = {18'd0, cfg.block_samples};
      REG_EXPIRY:     prdata = {1'b0, cfg.expiry_beats};
      REG_LATE:       prdata = {1'b0, cfg.late_tolerance};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

// ===== sv/bebs_checker.sv =====
// Port-level checker for the beat event block scheduler and its bind.
module bebs_checker import bebs_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid)
    else $error("result item dropped while stalled");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.kind != KIND_MATCH) |-> rsp.last && (rsp.sample_offset == 13'd0)
      && (rsp.out_node == 16'd0) && (rsp.out_value_bits == 32'd0))
    else $error("status item is not a clean final item");

  a_neg_refused: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && (req.func == FUNC_SCHED) && req.beat_time[31]
      |=> rsp_valid && (rsp.kind == KIND_REFUSE) && rsp.last)
    else $error("negative beat not refused");

  a_clear_empty: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && (req.func == FUNC_CLEAR)
      |=> rsp_valid && (rsp.kind == KIND_EMPTY) && rsp.last)
    else $error("clear item not answered as empty");

endmodule

bind beat_event_block_scheduler_core bebs_checker u_bebs_checker (.*);
